>>> design/frx_pkg.sv
package frx_pkg;

   localparam int MAX_PAYLOAD_DEF = 64;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   localparam logic [7:0] SYNC_U = 8'h55;
   localparam logic [7:0] SYNC_N = 8'h4E;
   localparam logic [7:0] SYNC_E = 8'h45;
   localparam logic [7:0] SYNC_R = 8'h52;

   localparam logic [7:0] VERSION_RESET = 8'h01;

   typedef enum logic [3:0] {
      ST_HUNT,
      ST_SYNC_N,
      ST_SYNC_E,
      ST_SYNC_R,
      ST_VERSION,
      ST_CMD,
      ST_FLAGS,
      ST_SEQ,
      ST_LEN,
      ST_PAYLOAD,
      ST_CRC_LO,
      ST_CRC_HI,
      ST_EMIT
   } state_type;

   // one byte through the crc, msb first
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> design/frame_receiver_crc16_top.sv
// channel | direction | handshake          | fields
// req     | in        | req_valid/req_stall | req_byte_in
// rsp     | out       | rsp_valid/rsp_stall | command, flags, sequence, length, index, byte, last
// csr     | in        | csr_wr_en           | csr_wr_data (version byte)
//
// one received word is taken per cycle while a frame is parsed; the crc of a
// word is folded in the same cycle
// a good frame then releases its payload from the store one word at a time, each
// word a store read then the output register, input stalled meanwhile
// synchronous active-high reset returns to the hunt for the first sync byte
// a stalled result holds; the store read is only issued once the output is free
module frame_receiver_crc16_top #(
   parameter int MAX_PAYLOAD = frx_pkg::MAX_PAYLOAD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_command,
   output logic [7:0] rsp_frame_flags,
   output logic [7:0] rsp_sequence_res,
   output logic [6:0] rsp_payload_length,
   output logic [5:0] rsp_byte_index,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import frx_pkg::*;

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   state_type   state_ff, state_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  version_ff;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  flags_ff, flags_in;
   logic [7:0]  seq_ff, seq_in;
   logic [6:0]  len_ff, len_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [6:0]  emit_idx_ff, emit_idx_in;
   logic        rd_pend_ff, rd_pend_in;
   logic [5:0]  rd_idx_ff, rd_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_cmd_ff, rsp_cmd_in;
   logic [7:0]  rsp_flags_ff, rsp_flags_in;
   logic [7:0]  rsp_seq_ff, rsp_seq_in;
   logic [6:0]  rsp_len_ff, rsp_len_in;
   logic [5:0]  rsp_idx_ff, rsp_idx_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        accept;
   logic        out_free;
   logic        ram_wr_en;
   logic        ram_rd_en;
   logic [7:0]  ram_rd_data;
   logic [6:0]  cnt_next;
   logic        pend_last;
   logic [7:0]  b;

   assign req_stall = (state_ff == ST_EMIT);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign b         = req_byte_in;
   assign cnt_next  = cnt_ff + 7'd1;
   assign pend_last = (({1'b0, rd_idx_ff} + 7'd1) == len_ff);

   frx_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (b),
      .rd_en   (ram_rd_en),
      .rd_addr (emit_idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      crc_in       = crc_ff;
      cmd_in       = cmd_ff;
      flags_in     = flags_ff;
      seq_in       = seq_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      crc_lo_in    = crc_lo_ff;
      emit_idx_in  = emit_idx_ff;
      rd_pend_in   = rd_pend_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      case (state_ff)
         ST_EMIT: begin
            if (rd_pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_cmd_in   = cmd_ff;
               rsp_flags_in = flags_ff;
               rsp_seq_in   = seq_ff;
               rsp_len_in   = len_ff;
               rsp_idx_in   = rd_idx_ff;
               rsp_byte_in  = ram_rd_data;
               rsp_last_in  = pend_last;
               rd_pend_in   = 1'b0;
               if (pend_last) begin
                  state_in = ST_HUNT;
               end
            end else if (out_free) begin
               if (len_ff == 7'd0) begin
                  // empty payload: a single closing word
                  rsp_valid_in = 1'b1;
                  rsp_cmd_in   = cmd_ff;
                  rsp_flags_in = flags_ff;
                  rsp_seq_in   = seq_ff;
                  rsp_len_in   = len_ff;
                  rsp_idx_in   = 6'd0;
                  rsp_byte_in  = 8'd0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_HUNT;
               end else begin
                  ram_rd_en   = 1'b1;
                  rd_pend_in  = 1'b1;
                  rd_idx_in   = emit_idx_ff[5:0];
                  emit_idx_in = emit_idx_ff + 7'd1;
               end
            end
         end
         ST_SYNC_N: begin
            if (accept) begin
               if (b == SYNC_N) begin
                  crc_in   = crc16_feed(crc_ff, b);
                  state_in = ST_SYNC_E;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_SYNC_E: begin
            if (accept) begin
               if (b == SYNC_E) begin
                  crc_in   = crc16_feed(crc_ff, b);
                  state_in = ST_SYNC_R;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_SYNC_R: begin
            if (accept) begin
               if (b == SYNC_R) begin
                  crc_in   = crc16_feed(crc_ff, b);
                  state_in = ST_VERSION;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_VERSION: begin
            if (accept) begin
               if (b == version_ff) begin
                  crc_in   = crc16_feed(crc_ff, b);
                  state_in = ST_CMD;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_CMD: begin
            if (accept) begin
               cmd_in   = b;
               crc_in   = crc16_feed(crc_ff, b);
               state_in = ST_FLAGS;
            end
         end
         ST_FLAGS: begin
            if (accept) begin
               flags_in = b;
               crc_in   = crc16_feed(crc_ff, b);
               state_in = ST_SEQ;
            end
         end
         ST_SEQ: begin
            if (accept) begin
               seq_in   = b;
               crc_in   = crc16_feed(crc_ff, b);
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (accept) begin
               if ({1'b0, b} > 9'(MAX_PAYLOAD)) begin
                  state_in = ST_HUNT;
               end else begin
                  len_in   = b[6:0];
                  cnt_in   = 7'd0;
                  crc_in   = crc16_feed(crc_ff, b);
                  state_in = (b == 8'd0) ? ST_CRC_LO : ST_PAYLOAD;
               end
            end
         end
         ST_PAYLOAD: begin
            if (accept) begin
               ram_wr_en = 1'b1;
               crc_in    = crc16_feed(crc_ff, b);
               cnt_in    = cnt_next;
               if (cnt_next >= len_ff) begin
                  state_in = ST_CRC_LO;
               end
            end
         end
         ST_CRC_LO: begin
            if (accept) begin
               crc_lo_in = b;
               state_in  = ST_CRC_HI;
            end
         end
         ST_CRC_HI: begin
            if (accept) begin
               if ({b, crc_lo_ff} == crc_ff) begin
                  emit_idx_in = 7'd0;
                  state_in    = ST_EMIT;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         default: begin
            if (accept) begin
               state_in = ST_HUNT;
               if (b == SYNC_U) begin
                  crc_in   = crc16_feed(CRC_INIT, b);
                  state_in = ST_SYNC_N;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT;
         crc_ff       <= CRC_INIT;
         version_ff   <= VERSION_RESET;
         cmd_ff       <= 8'd0;
         flags_ff     <= 8'd0;
         seq_ff       <= 8'd0;
         len_ff       <= 7'd0;
         cnt_ff       <= 7'd0;
         crc_lo_ff    <= 8'd0;
         emit_idx_ff  <= 7'd0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crc_ff       <= crc_in;
         cmd_ff       <= cmd_in;
         flags_ff     <= flags_in;
         seq_ff       <= seq_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         crc_lo_ff    <= crc_lo_in;
         emit_idx_ff  <= emit_idx_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            version_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      rsp_cmd_ff   <= rsp_cmd_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_seq_ff   <= rsp_seq_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_command        = rsp_cmd_ff;
   assign rsp_frame_flags    = rsp_flags_ff;
   assign rsp_sequence_res   = rsp_seq_ff;
   assign rsp_payload_length = rsp_len_ff;
   assign rsp_byte_index     = rsp_idx_ff;
   assign rsp_payload_byte   = rsp_byte_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

>>> design/frx_ram.sv
module frx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/frx_checker.sv
module frx_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_command,
   input logic [6:0] rsp_payload_length,
   input logic [5:0] rsp_byte_index,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_last
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_byte_index) && $stable(rsp_last) && $stable(rsp_command))
      else $error("stalled result word changed");

   // while a frame is still being released the input is held off
   a_emit_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken during payload release");

   // a store read sits between two words of one frame
   a_emit_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> !rsp_valid)
      else $error("payload words closer than the store read allows");

   // the closing word sits at the end of the payload
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |->
         (rsp_payload_length == 7'd0 && rsp_byte_index == 6'd0 && rsp_payload_byte == 8'd0)
         || (({1'b0, rsp_byte_index} + 7'd1) == rsp_payload_length))
      else $error("last word at wrong index");

   // a stalled request word stays offered
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("request word withdrawn while stalled");

endmodule

bind frame_receiver_crc16_top frx_checker u_frx_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_command        (rsp_command),
   .rsp_payload_length (rsp_payload_length),
   .rsp_byte_index     (rsp_byte_index),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_last           (rsp_last)
);
